// ===== hdl/single_wire_humidity_sensor_decoder_macros.svh =====
// assertion macros for the single-wire humidity sensor decoder
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_DECODER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SWHSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWHSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/swhsd_pkg.sv =====
// shared types and constants of the single-wire humidity sensor decoder
package swhsd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [5:0]  FRAME_BITS  = 6'd40;
    localparam logic [15:0] HUM_LIMIT   = 16'd1000;
    localparam logic [14:0] TEMP_LIMIT  = 15'd1250;

    localparam logic [7:0] BIT_THRESHOLD_RST   = 8'd35;
    localparam logic [7:0] TIMEOUT_TICKS_RST   = 8'd100;
    localparam logic [6:0] MAX_TRANSITIONS_RST = 7'd85;
    localparam logic [3:0] FIRST_DATA_RST      = 4'd4;

    typedef enum logic [1:0] {
        REG_BIT_THRESHOLD   = 2'd0,
        REG_TIMEOUT_TICKS   = 2'd1,
        REG_MAX_TRANSITIONS = 2'd2,
        REG_FIRST_DATA      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] bit_threshold;
        logic [7:0] timeout_ticks;
        logic [6:0] max_transitions;
        logic [3:0] first_data_transition;
    } cfg_t;

    // finished capture handed from the capture stage to the conversion stage
    typedef struct packed {
        logic [39:0] frame;
        logic [5:0]  bits;
        logic        by_timeout;
    } frame_t;

endpackage

// ===== hdl/swhsd_if.sv =====
// stream interfaces for line samples and decoded readings
interface swhsd_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink (input valid, input start_req, input line_level, output ready);
endinterface

interface swhsd_out_if;
    logic               valid;
    logic               ready;
    logic               reading_valid;
    logic [11:0]        humidity_tenths;
    logic signed [12:0] temperature_tenths;
    logic [5:0]         bit_count;
    logic               ended_by_timeout;

    modport source (
        output valid, output reading_valid, output humidity_tenths,
        output temperature_tenths, output bit_count, output ended_by_timeout,
        input ready
    );
    modport sink (
        input valid, input reading_valid, input humidity_tenths,
        input temperature_tenths, input bit_count, input ended_by_timeout,
        output ready
    );
endinterface

// ===== hdl/swhsd_regs.sv =====
// apb configuration registers of the decoder
module swhsd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swhsd_pkg::ADDR_W-1:0] paddr,
    input  logic [swhsd_pkg::DATA_W-1:0] pwdata,
    output logic [swhsd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output swhsd_pkg::cfg_t             cfg
);
    import swhsd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_threshold         <= BIT_THRESHOLD_RST;
            cfg_reg.timeout_ticks         <= TIMEOUT_TICKS_RST;
            cfg_reg.max_transitions       <= MAX_TRANSITIONS_RST;
            cfg_reg.first_data_transition <= FIRST_DATA_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BIT_THRESHOLD:   cfg_reg.bit_threshold         <= pwdata[7:0];
                REG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks         <= pwdata[7:0];
                REG_MAX_TRANSITIONS: cfg_reg.max_transitions       <= pwdata[6:0];
                REG_FIRST_DATA:      cfg_reg.first_data_transition <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BIT_THRESHOLD:   prdata = {24'd0, cfg_reg.bit_threshold};
            REG_TIMEOUT_TICKS:   prdata = {24'd0, cfg_reg.timeout_ticks};
            REG_MAX_TRANSITIONS: prdata = {25'd0, cfg_reg.max_transitions};
            REG_FIRST_DATA:      prdata = {28'd0, cfg_reg.first_data_transition};
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== hdl/swhsd_capture.sv =====
// phase timing, bit capture and frame hand-off register
module swhsd_capture (
    input  logic              clk,
    input  logic              rst_n,
    input  swhsd_pkg::cfg_t   cfg,
    swhsd_in_if.sink          in_ch,
    input  logic              frame_take,
    output logic              frame_valid,
    output swhsd_pkg::frame_t frame
);
    import swhsd_pkg::*;

    logic        cap_reg,     cap_next;
    logic        prev_reg,    prev_next;
    logic [7:0]  len_reg,     len_next;
    logic [6:0]  idx_reg,     idx_next;
    logic [5:0]  bits_reg,    bits_next;
    logic [39:0] shift_reg,   shift_next;
    logic        fvalid_reg,  fvalid_next;
    frame_t      frame_reg,   frame_next;

    logic        accept;
    logic [7:0]  len_inc;
    logic        take_bit;
    logic [39:0] shift_bit;
    logic [5:0]  bits_bit;
    logic [6:0]  idx_inc;

    // a new beat needs the hand-off slot free by the next edge
    assign in_ch.ready = !fvalid_reg || frame_take;
    assign accept      = in_ch.valid && in_ch.ready;
    assign frame_valid = fvalid_reg;
    assign frame       = frame_reg;

    assign len_inc   = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
    assign take_bit  = (idx_reg >= {3'd0, cfg.first_data_transition}) && !idx_reg[0]
                       && (bits_reg < FRAME_BITS);
    assign shift_bit = take_bit ? {shift_reg[38:0], (len_reg > cfg.bit_threshold)}
                                : shift_reg;
    assign bits_bit  = take_bit ? bits_reg + 6'd1 : bits_reg;
    assign idx_inc   = idx_reg + 7'd1;

    always_comb
    begin
        cap_next    = cap_reg;
        prev_next   = prev_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        fvalid_next = fvalid_reg && !frame_take;
        frame_next  = frame_reg;
        if (accept)
        begin
            if (in_ch.start_req)
            begin
                cap_next   = 1'b1;
                prev_next  = 1'b1;
                len_next   = '0;
                idx_next   = '0;
                bits_next  = '0;
                shift_next = '0;
            end
            else if (cap_reg)
            begin
                if (in_ch.line_level == prev_reg)
                begin
                    len_next = len_inc;
                    if (len_inc >= cfg.timeout_ticks)
                    begin
                        cap_next    = 1'b0;
                        fvalid_next = 1'b1;
                        frame_next  = '{frame: shift_reg, bits: bits_reg, by_timeout: 1'b1};
                    end
                end
                else
                begin
                    prev_next  = in_ch.line_level;
                    len_next   = '0;
                    idx_next   = idx_inc;
                    bits_next  = bits_bit;
                    shift_next = shift_bit;
                    if (idx_inc >= cfg.max_transitions)
                    begin
                        cap_next    = 1'b0;
                        fvalid_next = 1'b1;
                        frame_next  = '{frame: shift_bit, bits: bits_bit, by_timeout: 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= 1'b0;
            prev_reg   <= 1'b1;
            len_reg    <= '0;
            idx_reg    <= '0;
            bits_reg   <= '0;
            shift_reg  <= '0;
            fvalid_reg <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            prev_reg   <= prev_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            fvalid_reg <= fvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

// ===== hdl/swhsd_convert.sv =====
// checksum test, conversion to tenths and output register
module swhsd_convert (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  swhsd_pkg::frame_t frame,
    output logic              frame_take,
    swhsd_out_if.source       out_ch
);
    import swhsd_pkg::*;

    logic [7:0]         b0, b1, b2, b3, b4;
    logic [7:0]         sum;
    logic               ok;
    logic [15:0]        hum_raw;
    logic [14:0]        temp_raw;
    logic [11:0]        b0_x10, b2_x10;
    logic [11:0]        hum, temp_mag;
    logic [12:0]        temp_pos;
    logic [12:0]        temp;

    logic               out_v_reg,   out_v_next;
    logic               ok_reg;
    logic [11:0]        hum_reg;
    logic [12:0]        temp_reg;
    logic [5:0]         bits_reg;
    logic               tmo_reg;

    assign b0 = frame.frame[39:32];
    assign b1 = frame.frame[31:24];
    assign b2 = frame.frame[23:16];
    assign b3 = frame.frame[15:8];
    assign b4 = frame.frame[7:0];

    assign sum = b0 + b1 + b2 + b3;
    assign ok  = (frame.bits == FRAME_BITS) && (sum == b4);

    // times ten as the sum of two shifted copies
    assign b0_x10 = {1'b0, b0, 3'b000} + {3'b000, b0, 1'b0};
    assign b2_x10 = {1'b0, b2, 3'b000} + {3'b000, b2, 1'b0};

    assign hum_raw  = {b0, b1};
    assign temp_raw = {b2[6:0], b3};
    assign hum      = (hum_raw > HUM_LIMIT) ? b0_x10 : hum_raw[11:0];
    assign temp_mag = (temp_raw > TEMP_LIMIT) ? b2_x10 : temp_raw[11:0];
    assign temp_pos = {1'b0, temp_mag};
    assign temp     = b2[7] ? (13'd0 - temp_pos) : temp_pos;

    assign frame_take = !out_v_reg || out_ch.ready;
    assign out_v_next = frame_take ? frame_valid : out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take && frame_valid)
        begin
            ok_reg   <= ok;
            hum_reg  <= ok ? hum : 12'd0;
            temp_reg <= ok ? temp : 13'd0;
            bits_reg <= frame.bits;
            tmo_reg  <= frame.by_timeout;
        end
    end

    assign out_ch.valid              = out_v_reg;
    assign out_ch.reading_valid      = ok_reg;
    assign out_ch.humidity_tenths    = hum_reg;
    assign out_ch.temperature_tenths = signed'(temp_reg);
    assign out_ch.bit_count          = bits_reg;
    assign out_ch.ended_by_timeout   = tmo_reg;

endmodule

// ===== hdl/single_wire_humidity_sensor_decoder.sv =====
// top level of the single-wire humidity sensor decoder
//
//   port     dir  role                       beat contents
//   in_ch    in   one line sample per tick   start_req, line_level
//   out_ch   out  one reading per capture    reading_valid, humidity_tenths,
//                                            temperature_tenths, bit_count,
//                                            ended_by_timeout
//   apb      in   configuration registers    bit_threshold, timeout_ticks,
//                                            max_transitions, first_data_transition
//
// one input beat per cycle unless in_ch stalls; a finished capture goes to the hand-off
// register and then the output register; phase timing and bit capture update in the
// accept cycle, conversion sits before the output register
// reset clears the capture state, the hand-off slot and the output valid, registers to defaults
// in_ch stalls only while both the hand-off register and the output register are full and out_ch is not ready
`include "single_wire_humidity_sensor_decoder_macros.svh"

module single_wire_humidity_sensor_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swhsd_pkg::ADDR_W-1:0] paddr,
    input  logic [swhsd_pkg::DATA_W-1:0] pwdata,
    output logic [swhsd_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    swhsd_in_if.sink                     in_ch,
    swhsd_out_if.source                  out_ch
);
    import swhsd_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   frame_valid;
    logic   frame_take;

    swhsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swhsd_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_ch       (in_ch),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    swhsd_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .out_ch      (out_ch)
    );

    `SWHSD_ASSERT_NOW(a_bad_reading_zero, clk, rst_n, out_ch.valid && !out_ch.reading_valid, out_ch.humidity_tenths == 12'd0 && out_ch.temperature_tenths == 13'sd0, "invalid reading carries nonzero values")
    `SWHSD_ASSERT_NOW(a_good_full_frame, clk, rst_n, out_ch.valid && out_ch.reading_valid, out_ch.bit_count == FRAME_BITS, "good reading without a full frame")
    `SWHSD_ASSERT_NOW(a_range, clk, rst_n, out_ch.valid, out_ch.humidity_tenths <= 12'd2550 && out_ch.temperature_tenths <= 13'sd2550 && out_ch.temperature_tenths >= -13'sd2550 && out_ch.bit_count <= FRAME_BITS, "reading out of range")
    `SWHSD_ASSERT_NEXT(a_slot_fill, clk, rst_n, frame_valid && !frame_take, frame_valid && !in_ch.ready == !frame_take, "hand-off frame lost while stalled")

endmodule
